/* rtl/absolute_path_cleaner_unit_assert.svh */
// Assertion macros shared by the path cleaner RTL.
// Each macro expands to a clocked concurrent assertion on clk with rst_n as disable.
`ifndef ABSOLUTE_PATH_CLEANER_UNIT_ASSERT_SVH
`define ABSOLUTE_PATH_CLEANER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define APC_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("path cleaner assertion failed");
`define APC_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("path cleaner assertion failed");
`else
`define APC_ASSERT_ALWAYS(name, cond)
`define APC_ASSERT_NEXT(name, trig, cond)
`endif

`endif

/* rtl/apc_pkg.sv */
// Package for the path cleaner: capacity, field widths, character and phase codes.
// Used by absolute_path_cleaner_unit; depends on nothing.
`timescale 1ns / 1ps

package apc_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int CH_W     = 8;
    localparam int IDX_W    = 12;
    localparam int LEN_W    = 12;
    localparam int WIDE_W   = IDX_W + PTR_W;

    localparam logic [CH_W-1:0] SLASH = 8'h2F;
    localparam logic [CH_W-1:0] DOT   = 8'h2E;

    typedef logic [1:0] phase_t;

    localparam phase_t PH_BETWEEN  = 2'd0;
    localparam phase_t PH_ONE_DOT  = 2'd1;
    localparam phase_t PH_TWO_DOTS = 2'd2;
    localparam phase_t PH_NORMAL   = 2'd3;

endpackage

/* rtl/apc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the path cleaner keeps its character store in it.
`timescale 1ns / 1ps

module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/absolute_path_cleaner_unit.sv */
// Absolute path cleaner: a small sequencer around one character store RAM.
// Depends on apc_pkg, apc_ram and absolute_path_cleaner_unit_assert.svh.
//
// Usage. The input channel (in_valid / in_stall) carries one word per handshake:
// cmd = 0 pushes path byte ch, with last marking the final byte of the path;
// cmd = 1 reads the cleaned byte at read_index. The output channel
// (out_valid / out_stall) returns a read reply for every read and one
// end-of-path report for every push that carries last. Pushes without last
// give no word.
// Timing. in_stall is high while a word is being worked on. A read passes through
// S_RDWAIT and S_OUT, and its reply is loaded into the output register as it
// leaves S_OUT. A plain push runs S_START, S_TAKE and S_FINISH; S_PUTC follows
// S_TAKE when a separating slash is stored, and a slash goes from S_TAKE through
// S_CLOSE. A last push then runs S_CLOSE and S_REPORT, and its report is loaded
// into the output register as it leaves S_OUT. Closing a "." or ".." component
// walks the store backwards one character per cycle through the single RAM read
// port.
// The result sits in an output register: the next word is accepted while a
// finished result still waits, and the block holds in its output step only
// when a second result is ready and the receiver still stalls the first.
// Reset clears the control state; reads then give 0 and length 0 until a path.
`timescale 1ns / 1ps

`include "absolute_path_cleaner_unit_assert.svh"

module absolute_path_cleaner_unit
    import apc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  logic [CH_W-1:0]  ch,
    input  logic             last,
    input  logic [IDX_W-1:0] read_index,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             is_read_reply,
    output logic [CH_W-1:0]  out_char,
    output logic [LEN_W-1:0] out_length,
    output logic             not_absolute,
    output logic             overflow
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RDWAIT    = 4'd1;
    localparam logic [3:0] S_START     = 4'd2;
    localparam logic [3:0] S_TAKE      = 4'd3;
    localparam logic [3:0] S_PUTC      = 4'd4;
    localparam logic [3:0] S_FINISH    = 4'd5;
    localparam logic [3:0] S_CLOSE     = 4'd6;
    localparam logic [3:0] S_DROP      = 4'd7;
    localparam logic [3:0] S_DROP_WAIT = 4'd8;
    localparam logic [3:0] S_REPORT    = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    phase_t           phase_reg, phase_next;
    logic             awaiting_reg, awaiting_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       flags_reg, flags_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [1:0]       drops_reg, drops_next;
    logic             fin_reg, fin_next;

    logic             cmd_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             last_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CH_W-1:0]  char_reg, char_next;

    logic             out_valid_reg;
    logic             is_read_reg;
    logic [CH_W-1:0]  out_char_reg;
    logic [LEN_W-1:0] out_length_reg;
    logic [1:0]       out_flags_reg;

    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CH_W-1:0]  ram_wdata, ram_rdata;

    logic             in_accept, slot_free, load_out;
    logic [ADDR_W-1:0] cnt_v;
    logic [1:0]       flags_v;
    logic [PTR_W-1:0] wp_dec;
    logic [3:0]       done_state;
    logic [WIDE_W-1:0] idx_wide, wp_wide;
    logic             read_hit;
    logic             scan_in_path;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_OUT) && slot_free;

    assign idx_wide  = WIDE_W'(idx_reg);
    assign wp_wide   = WIDE_W'(wp_reg);
    assign read_hit  = idx_wide < wp_wide;
    assign wp_dec    = wp_reg - PTR_W'(1);
    assign done_state = fin_reg ? S_REPORT : S_FINISH;
    assign scan_in_path = (scan_reg != '0) && (PTR_W'(scan_reg) < wp_reg);

    apc_ram #(
        .WIDTH (CH_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        phase_next    = phase_reg;
        awaiting_next = awaiting_reg;
        cnt_next      = cnt_reg;
        flags_next    = flags_reg;
        scan_next     = scan_reg;
        drops_next    = drops_reg;
        fin_next      = fin_reg;
        char_next     = char_reg;
        cnt_v         = cnt_reg;
        flags_v       = flags_reg;
        ram_we        = 1'b0;
        ram_waddr     = wp_reg[ADDR_W-1:0];
        ram_wdata     = ch_reg;
        ram_raddr     = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Address the store straight from the port so read data is ready next cycle.
                ram_raddr = WIDE_W'(read_index) >= WIDE_W'(CAPACITY) ? '0 :
                            ADDR_W'(read_index);
                fin_next  = 1'b0;
                if (in_accept)
                begin
                    state_next = cmd ? S_RDWAIT : S_START;
                end
            end
            S_RDWAIT:
            begin
                char_next  = read_hit ? ram_rdata : '0;
                state_next = S_OUT;
            end
            S_START:
            begin
                if (awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    flags_v       = {1'b0, ch_reg != SLASH};
                    cnt_v         = '0;
                    phase_next    = PH_BETWEEN;
                    ram_we        = 1'b1;
                    ram_waddr     = '0;
                    ram_wdata     = SLASH;
                    wp_next       = PTR_W'(1);
                end
                if (cnt_v < ADDR_W'(CAPACITY - 1))
                begin
                    cnt_next   = cnt_v + ADDR_W'(1);
                    state_next = S_TAKE;
                end
                else
                begin
                    flags_v[1] = 1'b1;
                    cnt_next   = cnt_v;
                    state_next = S_FINISH;
                end
                flags_next = flags_v;
            end
            S_TAKE:
            begin
                if (ch_reg == SLASH)
                begin
                    state_next = S_CLOSE;
                end
                else if (phase_reg == PH_BETWEEN && wp_reg > PTR_W'(1))
                begin
                    // A new component after the root needs its separating slash first.
                    if (wp_reg < PTR_W'(CAPACITY))
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = SLASH;
                        wp_next   = wp_reg + PTR_W'(1);
                    end
                    state_next = S_PUTC;
                end
                else
                begin
                    if (wp_reg < PTR_W'(CAPACITY))
                    begin
                        ram_we  = 1'b1;
                        wp_next = wp_reg + PTR_W'(1);
                    end
                    case (phase_reg)
                        PH_BETWEEN: phase_next = (ch_reg == DOT) ? PH_ONE_DOT : PH_NORMAL;
                        PH_ONE_DOT: phase_next = (ch_reg == DOT) ? PH_TWO_DOTS : PH_NORMAL;
                        default:    phase_next = PH_NORMAL;
                    endcase
                    state_next = S_FINISH;
                end
            end
            S_PUTC:
            begin
                if (wp_reg < PTR_W'(CAPACITY))
                begin
                    ram_we  = 1'b1;
                    wp_next = wp_reg + PTR_W'(1);
                end
                phase_next = (ch_reg == DOT) ? PH_ONE_DOT : PH_NORMAL;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (last_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                phase_next = PH_BETWEEN;
                case (phase_reg)
                    PH_ONE_DOT:
                    begin
                        drops_next = 2'd1;
                        state_next = S_DROP;
                    end
                    PH_TWO_DOTS:
                    begin
                        drops_next = 2'd2;
                        state_next = S_DROP;
                    end
                    default:
                    begin
                        state_next = done_state;
                    end
                endcase
            end
            S_DROP:
            begin
                if (wp_reg == '0 || wp_dec == '0)
                begin
                    if (wp_reg != '0)
                    begin
                        wp_next = PTR_W'(1);
                    end
                    drops_next = drops_reg - 2'd1;
                    state_next = (drops_reg == 2'd1) ? done_state : S_DROP;
                end
                else
                begin
                    scan_next  = wp_dec[ADDR_W-1:0];
                    ram_raddr  = wp_dec[ADDR_W-1:0];
                    state_next = S_DROP_WAIT;
                end
            end
            S_DROP_WAIT:
            begin
                // One stored character per cycle, walking back toward the prior slash.
                if (ram_rdata == SLASH || scan_reg == ADDR_W'(1))
                begin
                    wp_next    = (ram_rdata == SLASH) ? PTR_W'(scan_reg) : PTR_W'(1);
                    drops_next = drops_reg - 2'd1;
                    state_next = (drops_reg == 2'd1) ? done_state : S_DROP;
                end
                else
                begin
                    scan_next = scan_reg - ADDR_W'(1);
                    ram_raddr = scan_reg - ADDR_W'(1);
                end
            end
            S_REPORT:
            begin
                awaiting_next = 1'b1;
                char_next     = '0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            phase_reg     <= PH_BETWEEN;
            awaiting_reg  <= 1'b1;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            drops_reg     <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            phase_reg    <= phase_next;
            awaiting_reg <= awaiting_next;
            cnt_reg      <= cnt_next;
            flags_reg    <= flags_next;
            drops_reg    <= drops_next;
            fin_reg      <= fin_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        char_reg <= char_next;
        if (in_accept)
        begin
            cmd_reg  <= cmd;
            ch_reg   <= ch;
            last_reg <= last;
            idx_reg  <= read_index;
        end
        if (load_out)
        begin
            is_read_reg    <= cmd_reg;
            out_char_reg   <= char_reg;
            out_length_reg <= wp_wide[LEN_W-1:0];
            out_flags_reg  <= flags_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_read_reply = is_read_reg;
    assign out_char      = out_char_reg;
    assign out_length    = out_length_reg;
    assign not_absolute  = out_flags_reg[0];
    assign overflow      = out_flags_reg[1];

    `APC_ASSERT_ALWAYS(a_wp_bound, wp_reg <= PTR_W'(CAPACITY))
    `APC_ASSERT_ALWAYS(a_scan_in_path, (state_reg == S_DROP_WAIT) |-> scan_in_path)
    `APC_ASSERT_ALWAYS(a_idle_between, (state_reg == S_IDLE && awaiting_reg) |-> (phase_reg == PH_BETWEEN))
    `APC_ASSERT_NEXT(a_out_from_seq, (state_reg != S_OUT && !out_valid_reg), !out_valid_reg)

endmodule
